// File: rtl/core/cat_pkg.sv
// ----------------------------------------------------------------------------
// cat_pkg
// Shared constants and controller/datapath interface types for the
// cumulative acknowledgement tracker.
// ----------------------------------------------------------------------------
package cat_pkg;

  localparam int NumConnDefault      = 16;
  localparam int PendingDepthDefault = 8;

  localparam int ConnIdW   = 4;
  localparam int SeqW      = 32;
  localparam int TimeoutW  = 16;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd240;

  localparam logic OpPacket = 1'b0;
  localparam logic OpTick   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init;
    logic conf;
    logic merge;
    logic commit;
    logic tick;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic in_range;
    logic merge_done;
    logic tick_last;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/cat_ram.sv
// ----------------------------------------------------------------------------
// cat_ram
// Generic single-write, single-read RAM with a registered read port.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module cat_ram #(
  parameter int Width = 32,
  parameter int Depth = 128,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/cat_ctrl.sv
// ----------------------------------------------------------------------------
// cat_ctrl
// Sequencing state machine of the acknowledgement tracker.
// ----------------------------------------------------------------------------
module cat_ctrl
  import cat_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StConf,
    StMerge,
    StCommit,
    StOutWait,
    StTick
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = StInit;
      end
      StInit: begin
        cmd_o.init = 1'b1;
        if (sts_i.is_tick)       state_d = StTick;
        else if (!sts_i.in_range) state_d = StIdle;
        else                      state_d = StConf;
      end
      StConf: begin
        cmd_o.conf = 1'b1;
        state_d    = StMerge;
      end
      StMerge: begin
        cmd_o.merge = 1'b1;
        if (sts_i.merge_done) state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit   = 1'b1;
        cmd_o.out_load = sts_i.out_free;
        state_d        = sts_i.out_free ? StIdle : StOutWait;
      end
      StOutWait: begin
        cmd_o.out_load = sts_i.out_free;
        if (sts_i.out_free) state_d = StIdle;
      end
      StTick: begin
        cmd_o.tick = 1'b1;
        if (sts_i.tick_last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

// File: rtl/core/cat_dp.sv
// ----------------------------------------------------------------------------
// cat_dp
// Datapath: connection records, pending-list merge and walk, idle timers,
// configuration register and output register.
// ----------------------------------------------------------------------------
module cat_dp
  import cat_pkg::*;
#(
  parameter int NumConn      = NumConnDefault,
  parameter int PendingDepth = PendingDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             sts_o,
  input  logic                op_i,
  input  logic [ConnIdW-1:0]  connection_id_i,
  input  logic [SeqW-1:0]     packet_seq_i,
  input  logic [SeqW-1:0]     sender_cum_seq_i,
  input  logic                cfg_we_i,
  input  logic [TimeoutW-1:0] cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ConnIdW-1:0]  ack_connection_o,
  output logic [SeqW-1:0]     ack_packet_seq_o,
  output logic [SeqW-1:0]     cum_seq_o
);

  localparam int CW  = (NumConn > 1) ? $clog2(NumConn) : 1;
  localparam int SW  = (PendingDepth > 1) ? $clog2(PendingDepth) : 1;
  localparam int SW1 = $clog2(PendingDepth + 1);
  localparam int RamDepth = NumConn * (2 ** SW);
  localparam int RamAW    = (RamDepth > 1) ? $clog2(RamDepth) : 1;

  // Item registers.
  logic                op_q;
  logic [ConnIdW-1:0]  conn_q;
  logic [SeqW-1:0]     seq_q;
  logic [SeqW-1:0]     scs_q;

  // Work registers.
  logic [SeqW-1:0]     cum_q;
  logic [SW1-1:0]      n_q, j_q, k_q, w_q;
  logic                ins_q, walk_q;
  logic [CW-1:0]       tick_q;

  logic [TimeoutW-1:0] timeout_q;
  logic [NumConn-1:0]  live_q;
  logic [SeqW-1:0]     cum_mem_q [NumConn];
  logic [SW1-1:0]      cnt_mem_q [NumConn];
  logic [TimeoutW-1:0] cd_mem_q  [NumConn];

  logic                out_valid_q;
  logic [ConnIdW-1:0]  out_conn_q;
  logic [SeqW-1:0]     out_seq_q;
  logic [SeqW-1:0]     out_cum_q;

  logic [CW-1:0]       cidx;
  logic                base_ok;
  logic [SeqW-1:0]     cum_base, cum_init;

  logic                ram_we, ram_re;
  logic [RamAW-1:0]    ram_waddr, ram_raddr;
  logic [SeqW-1:0]     ram_wdata, ram_rdata;

  logic                have_e, done, take_seq, dupe, hit, keep;
  logic [SeqW-1:0]     item, cum_inc;
  logic [SW1-1:0]      j_next;

  assign cidx = CW'(conn_q);

  // Restart and creation both begin from an empty record.
  assign base_ok  = live_q[cidx] && (scs_q != '0);
  assign cum_base = base_ok ? cum_mem_q[cidx] : '0;
  assign cum_init = (scs_q == '0) ? seq_q : ((cum_base < scs_q) ? scs_q : cum_base);

  // Merge of the stored list with the new sequence, one item per cycle.
  assign have_e   = (j_q < n_q);
  assign done     = (k_q == SW1'(PendingDepth)) || (!have_e && !ins_q);
  assign take_seq = ins_q && (!have_e || (seq_q < ram_rdata));
  assign dupe     = ins_q && have_e && (seq_q == ram_rdata);
  assign item     = take_seq ? seq_q : ram_rdata;
  assign cum_inc  = cum_q + 32'd1;
  assign hit      = (item == cum_inc);
  // Once the walk stops, every later item lies above the cumulative number.
  assign keep     = walk_q ? (!hit && (item > cum_q)) : 1'b1;
  assign j_next   = j_q + SW1'(1);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {cidx, SW'(0)};
    ram_we    = 1'b0;
    ram_waddr = {cidx, SW'(w_q)};
    ram_wdata = item;
    if (cmd_i.conf) begin
      ram_re = (n_q != '0);
    end else if (cmd_i.merge && !done) begin
      ram_re    = !take_seq && (j_next < n_q);
      ram_raddr = {cidx, SW'(j_next)};
      ram_we    = keep;
    end
  end

  cat_ram #(
    .Width (SeqW),
    .Depth (RamDepth)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      conn_q <= connection_id_i;
      seq_q  <= packet_seq_i;
      scs_q  <= sender_cum_seq_i;
    end
    if (cmd_i.init) begin
      cum_q <= cum_init;
      n_q   <= base_ok ? cnt_mem_q[cidx] : '0;
    end
    if (cmd_i.conf) begin
      j_q    <= '0;
      k_q    <= '0;
      w_q    <= '0;
      walk_q <= 1'b1;
      if (seq_q < cum_q) begin
        ins_q <= 1'b0;
      end else if (seq_q == cum_inc) begin
        cum_q <= seq_q;
        ins_q <= 1'b0;
      end else begin
        ins_q <= 1'b1;
      end
    end
    if (cmd_i.merge && !done) begin
      k_q <= k_q + SW1'(1);
      if (!take_seq) j_q <= j_next;
      if (take_seq || dupe) ins_q <= 1'b0;
      if (walk_q && hit) cum_q <= item;
      if (keep) begin
        walk_q <= 1'b0;
        w_q    <= w_q + SW1'(1);
      end
    end
    if (cmd_i.commit) begin
      cum_mem_q[cidx] <= cum_q;
      cnt_mem_q[cidx] <= w_q;
      cd_mem_q[cidx]  <= timeout_q;
    end
    if (cmd_i.tick && live_q[tick_q]) begin
      if (cd_mem_q[tick_q] <= 16'd1) cd_mem_q[tick_q] <= '0;
      else                           cd_mem_q[tick_q] <= cd_mem_q[tick_q] - 16'd1;
    end
    if (cmd_i.out_load) begin
      out_conn_q <= conn_q;
      out_seq_q  <= seq_q;
      out_cum_q  <= cum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutReset;
      live_q      <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        tick_q <= '0;
      end else if (cmd_i.tick) begin
        tick_q <= tick_q + CW'(1);
      end
      if (cmd_i.commit) begin
        live_q[cidx] <= 1'b1;
      end else if (cmd_i.tick && live_q[tick_q] && (cd_mem_q[tick_q] <= 16'd1)) begin
        live_q[tick_q] <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_tick    = (op_q == OpTick);
  assign sts_o.in_range   = (int'(conn_q) < NumConn);
  assign sts_o.merge_done = done;
  assign sts_o.tick_last  = (tick_q == CW'(NumConn - 1));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign ack_connection_o = out_conn_q;
  assign ack_packet_seq_o = out_seq_q;
  assign cum_seq_o        = out_cum_q;

endmodule

// File: rtl/core/cumulative_ack_tracker.sv
// ----------------------------------------------------------------------------
// cumulative_ack_tracker
// Per-connection cumulative acknowledgement tracker with idle expiry.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. How long a packet takes from acceptance
// to its result is set by the walk over the pending list, which reads one stored
// entry per cycle from a single list RAM. A packet whose result register is
// still occupied waits in place until the result is taken. A tick steps through
// the connection timers, one per cycle. Packets with a connection id at or
// above NumConn produce no result. The idle timeout register may be written at
// any time the block is idle.
module cumulative_ack_tracker
  import cat_pkg::*;
#(
  parameter int NumConn      = NumConnDefault,
  parameter int PendingDepth = PendingDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [ConnIdW-1:0]  connection_id_i,
  input  logic [SeqW-1:0]     packet_seq_i,
  input  logic [SeqW-1:0]     sender_cum_seq_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ConnIdW-1:0]  ack_connection_o,
  output logic [SeqW-1:0]     ack_packet_seq_o,
  output logic [SeqW-1:0]     cum_seq_o,
  input  logic                cfg_we_i,
  input  logic [TimeoutW-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t sts;

  cat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cat_dp #(
    .NumConn      (NumConn),
    .PendingDepth (PendingDepth)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .connection_id_i  (connection_id_i),
    .packet_seq_i     (packet_seq_i),
    .sender_cum_seq_i (sender_cum_seq_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ack_connection_o (ack_connection_o),
    .ack_packet_seq_o (ack_packet_seq_o),
    .cum_seq_o        (cum_seq_o)
  );

endmodule

// File: rtl/core/cat_checker.sv
// ----------------------------------------------------------------------------
// cat_checker
// Port-level assertions for the acknowledgement tracker, bound to the top.
// ----------------------------------------------------------------------------
module cat_checker
  import cat_pkg::*;
#(
  parameter int NumConn = NumConnDefault
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                op_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [ConnIdW-1:0]  ack_connection_o,
  input logic [SeqW-1:0]     ack_packet_seq_o,
  input logic [SeqW-1:0]     cum_seq_o
);

  // The block works on one transaction at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a transaction is in progress");

  // A tick never produces a result right after it is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i == OpTick)) |=> !$rose(out_valid_o))
    else $error("result appeared after a tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(ack_connection_o) < NumConn))
    else $error("result for an out-of-range connection");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(ack_connection_o) && $stable(ack_packet_seq_o)
       && $stable(cum_seq_o)))
    else $error("stalled result changed");

endmodule

bind cumulative_ack_tracker cat_checker #(.NumConn(NumConn)) u_cat_checker (.*);
